// ===== sv/afs_pkg.sv =====
package afs_pkg;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_CTRL      = 2'd1,
    CMD_READ_CLR  = 2'd2,
    CMD_PEEK      = 2'd3
  } cmd_t;

  localparam int unsigned COUNT_W = 15;

  localparam logic [COUNT_W-1:0] QUARTER_A = 15'd3728;
  localparam logic [COUNT_W-1:0] HALF_A    = 15'd7456;
  localparam logic [COUNT_W-1:0] QUARTER_B = 15'd11185;
  localparam logic [COUNT_W-1:0] END_FOUR  = 15'd14914;
  localparam logic [COUNT_W-1:0] END_FIVE  = 15'd18640;

  localparam int unsigned CTRL_FIVE_STEP_BIT = 7;
  localparam int unsigned CTRL_INHIBIT_BIT   = 6;

  typedef struct packed {
    cmd_t       command;
    logic       cycle_odd;
    logic [7:0] write_data;
    logic       pulse1_active;
    logic       pulse2_active;
    logic       triangle_active;
    logic       noise_active;
    logic       sample_busy;
    logic       sample_irq;
  } item_t;

  typedef struct packed {
    logic       quarter_clock;
    logic       half_clock;
    logic [7:0] status_data;
    logic       frame_irq;
  } result_t;

endpackage

// ===== sv/afs_core.sv =====
module afs_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  afs_pkg::item_t  item,
  output afs_pkg::result_t result
);
  import afs_pkg::*;

  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] frame_count_next;
  logic               reset_pending;
  logic               reset_pending_next;
  logic               frame_irq_flag;
  logic               frame_irq_flag_next;
  logic               five_step_mode;
  logic               five_step_mode_next;
  logic               irq_inhibit;
  logic               irq_inhibit_next;

  logic [COUNT_W-1:0] cnt_base;
  logic               seq_done;
  logic               qc;
  logic               hc;
  logic [7:0]         status;

  always_comb begin
    frame_count_next    = frame_count;
    reset_pending_next  = reset_pending;
    frame_irq_flag_next = frame_irq_flag;
    five_step_mode_next = five_step_mode;
    irq_inhibit_next    = irq_inhibit;
    cnt_base            = frame_count;
    seq_done            = 1'b0;
    qc                  = 1'b0;
    hc                  = 1'b0;
    status              = 8'd0;
    case (item.command)
      CMD_TICK: begin
        if (item.cycle_odd) begin
          if (reset_pending) begin
            cnt_base           = '0;
            reset_pending_next = 1'b0;
            if (five_step_mode) begin
              hc = 1'b1;
            end
          end
          if (cnt_base == QUARTER_A || cnt_base == QUARTER_B) begin
            qc = 1'b1;
          end else if (cnt_base == HALF_A) begin
            hc = 1'b1;
          end else if (cnt_base == END_FOUR && !five_step_mode) begin
            hc       = 1'b1;
            seq_done = 1'b1;
            if (!irq_inhibit) begin
              frame_irq_flag_next = 1'b1;
            end
          end else if (cnt_base == END_FIVE && five_step_mode) begin
            hc       = 1'b1;
            seq_done = 1'b1;
          end
          frame_count_next = seq_done ? '0 : cnt_base + COUNT_W'(1);
        end
      end
      CMD_CTRL: begin
        five_step_mode_next = item.write_data[CTRL_FIVE_STEP_BIT];
        irq_inhibit_next    = item.write_data[CTRL_INHIBIT_BIT];
        reset_pending_next  = 1'b1;
        if (item.write_data[CTRL_INHIBIT_BIT]) begin
          frame_irq_flag_next = 1'b0;
        end
      end
      CMD_READ_CLR, CMD_PEEK: begin
        status = {item.sample_irq, frame_irq_flag, 1'b0, item.sample_busy,
                  item.noise_active, item.triangle_active,
                  item.pulse2_active, item.pulse1_active};
        if (item.command == CMD_READ_CLR) begin
          frame_irq_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.quarter_clock = qc | hc;
  assign result.half_clock    = hc;
  assign result.status_data   = status;
  assign result.frame_irq     = frame_irq_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      reset_pending  <= 1'b0;
      frame_irq_flag <= 1'b0;
      five_step_mode <= 1'b0;
      irq_inhibit    <= 1'b0;
    end else if (step_en) begin
      frame_count    <= frame_count_next;
      reset_pending  <= reset_pending_next;
      frame_irq_flag <= frame_irq_flag_next;
      five_step_mode <= five_step_mode_next;
      irq_inhibit    <= irq_inhibit_next;
    end
  end

endmodule

// ===== sv/audio_frame_sequencer_top.sv =====
// Channel  Dir  Width            Contents
// s_axis   in   tdata 16, user 2 one request: tick, control write, status read/peek
// m_axis   out  tdata 16         one result per request
//
// Each request is registered at the input, evaluated combinationally against
// the sequencer state, and registered at the output.
// Sustained rate is one request per cycle while the output is not stalled;
// the state update is one compare chain and a 15-bit increment.
// rst is synchronous and clears the count, flags, mode and both valid stages.
// A stalled output holds its result; the input stage keeps accepting until it
// also holds a request.
module audio_frame_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] cycle_odd, [8:1] write_data, [9] pulse1_active, [10] pulse2_active,
  // [11] triangle_active, [12] noise_active, [13] sample_busy, [14] sample_irq,
  // [15] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] quarter_clock, [1] half_clock, [9:2] status_data, [10] frame_irq,
  // [15:11] zero
  output logic [15:0] m_axis_tdata
);
  import afs_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_free;
  logic    advance;
  result_t step_result;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.command         <= cmd_t'(s_axis_tuser);
      in_item.cycle_odd       <= s_axis_tdata[0];
      in_item.write_data      <= s_axis_tdata[8:1];
      in_item.pulse1_active   <= s_axis_tdata[9];
      in_item.pulse2_active   <= s_axis_tdata[10];
      in_item.triangle_active <= s_axis_tdata[11];
      in_item.noise_active    <= s_axis_tdata[12];
      in_item.sample_busy     <= s_axis_tdata[13];
      in_item.sample_irq      <= s_axis_tdata[14];
    end
  end

  afs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (in_item),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'd0, step_result.frame_irq, step_result.status_data,
                       step_result.half_clock, step_result.quarter_clock};
    end
  end

endmodule

// ===== sv/afs_checker.sv =====
module afs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_half_has_quarter: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("half clock without quarter clock");

  a_clock_no_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9:2] == 8'd0)
    else $error("sequencer clock together with status byte");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0 && !m_axis_tdata[7])
    else $error("reserved result bits set");

endmodule

bind audio_frame_sequencer_top afs_checker u_afs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/audio_frame_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module audio_frame_sequencer_top_tb;
  import afs_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1750;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 50;

  typedef enum int unsigned {
    RDY_FULL,
    RDY_RANDOM,
    RDY_PERIODIC,
    RDY_HOLD
  } ready_mode_t;

  class frame_sequencer_scoreboard;
    logic [COUNT_W-1:0] count;
    logic reset_req;
    logic irq_flag;
    logic five_step;
    logic inhibit;
    result_t expected_results[$];
    int unsigned mismatches;

    function new();
      count = '0;
      reset_req = 1'b0;
      irq_flag = 1'b0;
      five_step = 1'b0;
      inhibit = 1'b0;
      mismatches = 0;
    endfunction

    function void note_request(logic [15:0] data, logic [1:0] user);
      result_t res;
      cmd_t cmd;
      logic seq_done;
      res = '0;
      cmd = cmd_t'(user);
      seq_done = 1'b0;
      case (cmd)
        CMD_TICK: begin
          if (data[0]) begin
            if (reset_req) begin
              count = '0;
              reset_req = 1'b0;
              if (five_step) begin
                res.half_clock = 1'b1;
              end
            end
            if (count == QUARTER_A || count == QUARTER_B) begin
              res.quarter_clock = 1'b1;
            end else if (count == HALF_A) begin
              res.half_clock = 1'b1;
            end else if (count == END_FOUR && !five_step) begin
              res.half_clock = 1'b1;
              if (!inhibit) begin
                irq_flag = 1'b1;
              end
              seq_done = 1'b1;
            end else if (count == END_FIVE && five_step) begin
              res.half_clock = 1'b1;
              seq_done = 1'b1;
            end
            count = seq_done ? '0 : count + 1'b1;
            if (res.half_clock) begin
              res.quarter_clock = 1'b1;
            end
          end
        end
        CMD_CTRL: begin
          five_step = data[1 + CTRL_FIVE_STEP_BIT];
          inhibit = data[1 + CTRL_INHIBIT_BIT];
          if (inhibit) begin
            irq_flag = 1'b0;
          end
          reset_req = 1'b1;
        end
        default: begin
          res.status_data = {data[14], irq_flag, 1'b0, data[13:9]};
          if (cmd == CMD_READ_CLR) begin
            irq_flag = 1'b0;
          end
        end
      endcase
      res.frame_irq = irq_flag;
      expected_results.push_back(res);
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      if (mismatches < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
      mismatches++;
    endfunction

    function void check_result(logic [15:0] data);
      result_t want;
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: result with none expected, expected none, actual %h", $time, data);
        end
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (data[0] !== want.quarter_clock) begin
          report("quarter_clock", {7'd0, want.quarter_clock}, {7'd0, data[0]});
        end
        if (data[1] !== want.half_clock) begin
          report("half_clock", {7'd0, want.half_clock}, {7'd0, data[1]});
        end
        if (data[9:2] !== want.status_data) begin
          report("status_data", want.status_data, data[9:2]);
        end
        if (data[10] !== want.frame_irq) begin
          report("frame_irq", {7'd0, want.frame_irq}, {7'd0, data[10]});
        end
        if (data[15:11] !== 5'd0) begin
          report("padding", 8'h00, {3'b000, data[15:11]});
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  frame_sequencer_scoreboard tracker = new();

  int unsigned burst_left = 0;
  int unsigned burst_max = 16;
  int unsigned gap_max = 8;
  int unsigned cycles = 0;

  ready_mode_t ready_mode = RDY_FULL;
  int unsigned window_left = 0;
  int unsigned window_pos = 0;

  audio_frame_sequencer_top uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_request(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_result(m_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        window_left <= $urandom_range(64, 256);
        window_pos <= 0;
      end else begin
        window_left <= window_left - 1;
        window_pos <= window_pos + 1;
      end
      case (ready_mode)
        RDY_FULL: m_axis_tready <= 1'b1;
        RDY_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RDY_PERIODIC: m_axis_tready <= (window_pos % 3 != 0);
        default: m_axis_tready <= (window_pos >= 24);
      endcase
    end
  end

  task automatic send_request(input cmd_t cmd, input logic odd, input logic [7:0] wd,
                              input logic [5:0] chan);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, chan, wd, odd};
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (tracker.expected_results.size() != 0);
    @(posedge clk);
    burst_left = 0;
  endtask

  // write control, then run the given odd ticks with a few reads and even ticks mixed in
  task automatic run_sequence(input logic [7:0] ctrl, input int unsigned odd_ticks);
    int unsigned done_ticks;
    int unsigned pick;
    done_ticks = 0;
    send_request(CMD_CTRL, 1'($urandom_range(0, 1)), ctrl, 6'($urandom_range(0, 63)));
    while (done_ticks < odd_ticks) begin
      pick = $urandom_range(0, 255);
      if (pick == 0) begin
        send_request(CMD_READ_CLR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else if (pick < 4) begin
        send_request(CMD_PEEK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else if (pick < 36) begin
        send_request(CMD_TICK, 1'b0, 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else begin
        send_request(CMD_TICK, 1'b1, 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
        done_ticks++;
      end
    end
  endtask

  initial begin
    int unsigned pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(CMD_PEEK, 1'b0, 8'h00, 6'h00);
    send_request(CMD_PEEK, 1'b1, 8'hFF, 6'h3F);
    send_request(CMD_READ_CLR, 1'b0, 8'h00, 6'h2A);
    send_request(CMD_READ_CLR, 1'b1, 8'hFF, 6'h15);
    send_request(CMD_TICK, 1'b0, 8'hFF, 6'h3F);
    send_request(CMD_TICK, 1'b1, 8'h00, 6'h00);
    send_request(CMD_CTRL, 1'b0, 8'hFF, 6'h00);
    send_request(CMD_TICK, 1'b0, 8'h55, 6'h3F);
    send_request(CMD_PEEK, 1'b0, 8'hAA, 6'h3F);
    send_request(CMD_TICK, 1'b1, 8'h00, 6'h00);
    send_request(CMD_TICK, 1'b1, 8'hFF, 6'h3F);
    send_request(CMD_CTRL, 1'b1, 8'h80, 6'h3F);
    send_request(CMD_TICK, 1'b1, 8'h00, 6'h00);
    send_request(CMD_CTRL, 1'b0, 8'h40, 6'h00);
    send_request(CMD_TICK, 1'b1, 8'hFF, 6'h00);
    send_request(CMD_CTRL, 1'b1, 8'h3F, 6'h3F);
    send_request(CMD_TICK, 1'b1, 8'h00, 6'h3F);
    send_request(CMD_CTRL, 1'b0, 8'h00, 6'h00);
    send_request(CMD_TICK, 1'b0, 8'h00, 6'h00);
    send_request(CMD_TICK, 1'b1, 8'hFF, 6'h00);
    send_request(CMD_READ_CLR, 1'b0, 8'h00, 6'h3F);
    wait_drained();

    burst_max = 256;
    run_sequence({2'b00, 6'($urandom_range(0, 63))}, 18800);
    wait_drained();

    burst_max = 24;
    repeat (RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 15);
      if (pick < 7) begin
        send_request(CMD_TICK, 1'b1, 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else if (pick < 9) begin
        send_request(CMD_TICK, 1'b0, 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else if (pick < 11) begin
        send_request(CMD_CTRL, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else if (pick < 13) begin
        send_request(CMD_READ_CLR, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end else begin
        send_request(CMD_PEEK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
      end
    end
    wait_drained();

    burst_max = 256;
    run_sequence({2'b10, 6'($urandom_range(0, 63))}, 22500);
    run_sequence({2'b01, 6'($urandom_range(0, 63))}, 15000);
    run_sequence({2'b11, 6'($urandom_range(0, 63))}, 4000);
    send_request(CMD_PEEK, 1'b0, 8'h00, 6'h3F);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
